/* rtl/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, request codes, sequencer states and the result type of
// the bitmap word unit.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned N_PAGES   = 65536;
  localparam int unsigned MAX_RUN   = 256;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OFF_W     = $clog2(WORD_W);
  localparam int unsigned NUM_WORDS = N_PAGES / WORD_W;
  localparam int unsigned ADDR_W    = $clog2(NUM_WORDS);
  localparam int unsigned POS_W     = $clog2(N_PAGES) + 1;
  localparam int unsigned RUN_W     = $clog2(MAX_RUN) + 1;
  localparam int unsigned POP_W     = OFF_W + 1;

  typedef enum logic [2:0] {
    REQ_INIT_BEGIN  = 3'd0,
    REQ_INIT_REGION = 3'd1,
    REQ_INIT_END    = 3'd2,
    REQ_ALLOC       = 3'd3,
    REQ_FREE        = 3'd4
  } req_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_FILL,
    ST_RNG_RD,
    ST_RNG_WR,
    ST_AL_RD,
    ST_AL_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [WORD_W-1:0] new_word;
    logic [POP_W-1:0]  changed;
    logic              all_free;
    logic              all_used;
    logic              bit_used;
  } wu_res_t;

endpackage

/* rtl/bpa_ram.sv */
// ----------------------------------------------------------------------------
// bpa_ram
// Bitmap store: one word of used bits per address, one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [bpa_pkg::ADDR_W-1:0]             waddr_i,
  input  logic [bpa_pkg::WORD_W-1:0]             wdata_i,
  input  logic [bpa_pkg::ADDR_W-1:0]             raddr_i,
  output logic [bpa_pkg::WORD_W-1:0]             rdata_o
);
  import bpa_pkg::*;

  logic [WORD_W-1:0] mem [NUM_WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/bpa_word_unit.sv */
// ----------------------------------------------------------------------------
// bpa_word_unit
// Shared word unit: masks a bitmap word from a start offset up to an optional
// end offset, sets or clears those bits, counts flipped bits and reports
// whether the bits from the start offset are all free or all used.
// ----------------------------------------------------------------------------
module bpa_word_unit (
  input  logic [bpa_pkg::WORD_W-1:0] word_i,
  input  logic [bpa_pkg::OFF_W-1:0]  lo_off_i,
  input  logic                       has_end_i,
  input  logic [bpa_pkg::OFF_W-1:0]  end_off_i,
  input  logic                       set_i,
  output bpa_pkg::wu_res_t           res_o
);
  import bpa_pkg::*;

  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] end_mask;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] new_word;

  always_comb begin
    lo_mask  = {WORD_W{1'b1}} << lo_off_i;
    end_mask = has_end_i ? ~({WORD_W{1'b1}} << end_off_i) : {WORD_W{1'b1}};
    mask     = lo_mask & end_mask;
    new_word = set_i ? (word_i | mask) : (word_i & ~mask);
    res_o.new_word = new_word;
    res_o.changed  = POP_W'($countones(word_i ^ new_word));
    res_o.all_free = (word_i & lo_mask) == '0;
    res_o.all_used = (~word_i & lo_mask) == '0;
    res_o.bit_used = word_i[lo_off_i];
  end

endmodule

/* rtl/bpa_ctrl.sv */
// ----------------------------------------------------------------------------
// bpa_ctrl
// Request sequencer: decodes an item, sweeps the bitmap word by word through
// the shared word unit, keeps the page counts and holds the result register.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  req_type_i,
  input  logic [51:0]                 page_number_i,
  input  logic [23:0]                 page_count_i,
  input  logic [3:0]                  mem_type_i,
  input  logic [16:0]                 reserved_i,
  input  logic [15:0]                 type_mask_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        status_o,
  output logic [15:0]                 alloc_page_o,
  output logic [16:0]                 used_count_o,
  output logic [16:0]                 free_count_o,
  output logic [16:0]                 total_count_o,
  output logic                        ram_we_o,
  output logic [bpa_pkg::ADDR_W-1:0]  ram_waddr_o,
  output logic [bpa_pkg::WORD_W-1:0]  ram_wdata_o,
  output logic [bpa_pkg::ADDR_W-1:0]  ram_raddr_o,
  input  logic [bpa_pkg::WORD_W-1:0]  ram_rdata_i
);
  import bpa_pkg::*;

  localparam logic [POS_W-1:0] PagesEnd = POS_W'(N_PAGES);

  state_e state_q, state_d;
  logic [2:0]       req_q, req_d;
  logic [51:0]      page_q, page_d;
  logic [23:0]      cnt_q, cnt_d;
  logic [3:0]       type_q, type_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] hi_q, hi_d;
  logic             set_q, set_d;
  logic [RUN_W-1:0] run_q, run_d;
  logic             status_q, status_d;
  logic [15:0]      alloc_q, alloc_d;
  logic [16:0]      used_q, used_d;
  logic [16:0]      total_q, total_d;
  logic             out_valid_q, out_valid_d;
  logic             o_status_q, o_status_d;
  logic [15:0]      o_alloc_q, o_alloc_d;
  logic [16:0]      o_used_q, o_used_d;
  logic [16:0]      o_free_q, o_free_d;
  logic [16:0]      o_total_q, o_total_d;

  wu_res_t          wu;
  logic [OFF_W-1:0] pos_off;
  logic [POS_W-1:0] pos_next_word;
  logic             has_end;
  logic             word_last;
  logic             scan_end;
  logic [OFF_W:0]   n_bits;
  logic [RUN_W:0]   run_plus_n;
  logic [RUN_W-1:0] cnt_run;
  logic [RUN_W-1:0] run_inc;
  logic             found_word;
  logic             found_bit;
  logic [POS_W-1:0] start_word;
  logic [POS_W-1:0] start_bit;
  logic             page_in;
  logic [52:0]      range_sum;
  logic [POS_W-1:0] sum_clamp;
  logic [POS_W-1:0] res_clamp;
  logic             mask_ok;
  logic             alloc_ok;
  logic             out_free;

  assign pos_off       = pos_q[OFF_W-1:0];
  assign pos_next_word = {pos_q[POS_W-1:OFF_W] + (POS_W-OFF_W)'(1), {OFF_W{1'b0}}};
  assign has_end       = hi_q[POS_W-1:OFF_W] == pos_q[POS_W-1:OFF_W];
  assign word_last     = pos_next_word >= hi_q;
  assign scan_end      = pos_next_word >= PagesEnd;
  assign n_bits        = (OFF_W+1)'(WORD_W) - {1'b0, pos_off};
  assign run_plus_n    = {1'b0, run_q} + (RUN_W+1)'(n_bits);
  assign cnt_run       = cnt_q[RUN_W-1:0];
  assign run_inc       = run_q + RUN_W'(1);
  assign found_word    = wu.all_free && (run_plus_n >= {1'b0, cnt_run});
  assign found_bit     = !wu.all_free && !wu.all_used && !wu.bit_used && (run_inc == cnt_run);
  assign start_word    = pos_q - POS_W'(run_q);
  assign start_bit     = pos_q + POS_W'(1) - POS_W'(cnt_run);
  assign page_in       = page_q[51:POS_W-1] == '0;
  assign range_sum     = {1'b0, page_q} + 53'(cnt_q);
  assign sum_clamp     = (range_sum >= 53'(N_PAGES)) ? PagesEnd : range_sum[POS_W-1:0];
  assign res_clamp     = (reserved_i >= PagesEnd) ? PagesEnd : reserved_i;
  assign mask_ok       = type_mask_i[type_q];
  assign alloc_ok      = (cnt_q != '0) && (cnt_q <= 24'(MAX_RUN)) && (reserved_i < PagesEnd);
  assign out_free      = !out_valid_q || out_ready_i;

  bpa_word_unit u_word_unit (
    .word_i    (ram_rdata_i),
    .lo_off_i  (pos_off),
    .has_end_i (has_end),
    .end_off_i (hi_q[OFF_W-1:0]),
    .set_i     (set_q),
    .res_o     (wu)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (scan_end) state_d = ST_IDLE;
      ST_FILL:   if (scan_end) state_d = ST_DONE;
      ST_IDLE:   if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        state_d = ST_DONE;
        case (req_q)
          REQ_INIT_BEGIN:  state_d = ST_FILL;
          REQ_INIT_REGION: if (mask_ok && page_in && cnt_q != '0) state_d = ST_RNG_RD;
          REQ_FREE:        if (page_in && cnt_q != '0) state_d = ST_RNG_RD;
          REQ_INIT_END:    if (res_clamp != '0) state_d = ST_RNG_RD;
          REQ_ALLOC:       if (alloc_ok) state_d = ST_AL_RD;
          default:         state_d = ST_DONE;
        endcase
      end
      ST_RNG_RD: state_d = ST_RNG_WR;
      ST_RNG_WR: state_d = word_last ? ST_DONE : ST_RNG_RD;
      ST_AL_RD:  state_d = ST_AL_CHK;
      ST_AL_CHK: begin
        if (found_word || found_bit) begin
          state_d = ST_RNG_RD;
        end else if (wu.all_used || wu.all_free || pos_off == '1) begin
          state_d = scan_end ? ST_DONE : ST_AL_RD;
        end
      end
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    req_d       = req_q;
    page_d      = page_q;
    cnt_d       = cnt_q;
    type_d      = type_q;
    pos_d       = pos_q;
    hi_d        = hi_q;
    set_d       = set_q;
    run_d       = run_q;
    status_d    = status_q;
    alloc_d     = alloc_q;
    used_d      = used_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_status_d  = o_status_q;
    o_alloc_d   = o_alloc_q;
    o_used_d    = o_used_q;
    o_free_d    = o_free_q;
    o_total_d   = o_total_q;
    ram_we_o    = 1'b0;
    ram_wdata_o = wu.new_word;
    ram_waddr_o = pos_q[POS_W-2:OFF_W];
    ram_raddr_o = pos_q[POS_W-2:OFF_W];
    unique case (state_q)
      ST_CLEAR, ST_FILL: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = (state_q == ST_FILL) ? {WORD_W{1'b1}} : {WORD_W{1'b0}};
        pos_d       = pos_next_word;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d  = req_type_i;
          page_d = page_number_i;
          cnt_d  = page_count_i;
          type_d = mem_type_i;
        end
      end
      ST_DECODE: begin
        status_d = 1'b0;
        alloc_d  = '0;
        set_d    = 1'b1;
        run_d    = '0;
        case (req_q)
          REQ_INIT_BEGIN: begin
            used_d  = 17'(N_PAGES);
            total_d = 17'(N_PAGES);
            pos_d   = '0;
          end
          REQ_INIT_REGION, REQ_FREE: begin
            pos_d = page_q[POS_W-1:0];
            hi_d  = sum_clamp;
            set_d = 1'b0;
          end
          REQ_INIT_END: begin
            pos_d = '0;
            hi_d  = res_clamp;
          end
          REQ_ALLOC: begin
            status_d = 1'b1;
            pos_d    = reserved_i;
          end
          default: ;
        endcase
      end
      ST_RNG_WR: begin
        ram_we_o = 1'b1;
        pos_d    = pos_next_word;
        if (set_q) begin
          used_d = used_q + 17'(wu.changed);
        end else begin
          used_d = (used_q >= 17'(wu.changed)) ? used_q - 17'(wu.changed) : '0;
        end
      end
      ST_AL_CHK: begin
        if (found_word) begin
          pos_d    = start_word;
          hi_d     = start_word + POS_W'(cnt_run);
          status_d = 1'b0;
          alloc_d  = start_word[15:0];
        end else if (found_bit) begin
          pos_d    = start_bit;
          hi_d     = start_bit + POS_W'(cnt_run);
          status_d = 1'b0;
          alloc_d  = start_bit[15:0];
        end else if (wu.all_used) begin
          run_d = '0;
          pos_d = pos_next_word;
        end else if (wu.all_free) begin
          run_d = run_plus_n[RUN_W-1:0];
          pos_d = pos_next_word;
        end else begin
          run_d = wu.bit_used ? '0 : run_inc;
          pos_d = pos_q + POS_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_status_d  = status_q;
          o_alloc_d   = alloc_q;
          o_used_d    = used_q;
          o_total_d   = total_q;
          o_free_d    = (total_q > used_q) ? total_q - used_q : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pos_q       <= '0;
      used_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      used_q      <= used_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    page_q     <= page_d;
    cnt_q      <= cnt_d;
    type_q     <= type_d;
    hi_q       <= hi_d;
    set_q      <= set_d;
    run_q      <= run_d;
    status_q   <= status_d;
    alloc_q    <= alloc_d;
    o_status_q <= o_status_d;
    o_alloc_q  <= o_alloc_d;
    o_used_q   <= o_used_d;
    o_free_q   <= o_free_d;
    o_total_q  <= o_total_d;
  end

  assign in_ready_o    = state_q == ST_IDLE;
  assign out_valid_o   = out_valid_q;
  assign status_o      = o_status_q;
  assign alloc_page_o  = o_alloc_q;
  assign used_count_o  = o_used_q;
  assign free_count_o  = o_free_q;
  assign total_count_o = o_total_q;

endmodule

/* rtl/bitmap_page_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Physical page allocator with one used bit per page, kept in a word-wide
// bitmap store and updated by a sequencer through a shared word unit.
// ----------------------------------------------------------------------------
// Init begin fills the bitmap with one word written per cycle; range updates
// read and write back each 32-page word touched; allocation reads and checks
// each word skipped, or steps page by page inside a mixed word, then marks
// the run. One item is in work at a time; the result register lets the next
// item enter while a result waits. After reset a clearing pass over all 2048
// words zeroes the bitmap before the first item is taken.
module bitmap_page_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [51:0] page_number_i,
  input  logic [23:0] page_count_i,
  input  logic [3:0]  mem_type_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [15:0] alloc_page_o,
  output logic [16:0] used_count_o,
  output logic [16:0] free_count_o,
  output logic [16:0] total_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bpa_pkg::*;

  localparam logic RegReserved = 1'b0;
  localparam logic RegTypeMask = 1'b1;

  logic [16:0] reserved_q;
  logic [15:0] type_mask_q;
  logic        cfg_wr;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q  <= 17'd512;
      type_mask_q <= 16'd152;
    end else if (cfg_wr) begin
      if (paddr[2] == RegReserved) begin
        reserved_q <= pwdata[16:0];
      end else begin
        type_mask_q <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == RegTypeMask) ? {16'd0, type_mask_q} : {15'd0, reserved_q};

  bpa_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bpa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .page_number_i (page_number_i),
    .page_count_i  (page_count_i),
    .mem_type_i    (mem_type_i),
    .reserved_i    (reserved_q),
    .type_mask_i   (type_mask_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .alloc_page_o  (alloc_page_o),
    .used_count_o  (used_count_o),
    .free_count_o  (free_count_o),
    .total_count_o (total_count_o),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

endmodule
